// File: hdl/assert_macros.svh
// Assertion macros used by the checker file rtcat_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked also during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rtcat_pkg.sv
// Types, constants and calendar helpers for the alarm time calculator.
// No dependencies.
`default_nettype none

package rtcat_pkg;

   // Transfer payloads
   typedef struct packed {
      logic [6:0]  cur_year;
      logic [3:0]  cur_month;
      logic [4:0]  cur_day;
      logic [4:0]  cur_hours;
      logic [5:0]  cur_minutes;
      logic [5:0]  cur_seconds;
      logic [31:0] offset_seconds;
   } req_type;

   typedef struct packed {
      logic [31:0] target_epoch;
      logic [7:0]  alarm_year;
      logic [3:0]  alarm_month;
      logic [4:0]  alarm_day;
      logic [4:0]  alarm_hours;
      logic [5:0]  alarm_minutes;
      logic [5:0]  alarm_seconds;
   } rsp_type;

   // Between the divider and the calendar stages
   typedef struct packed {
      logic [31:0] target;
      logic [15:0] left;
      logic [16:0] rem;
   } div_type;

   localparam logic [31:0] DAY_SECS   = 32'd86400;
   // floor(x / 675) for x < 2^25 is (x * DAY_RECIP) >> 35
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;
   // floor(x / 225) for x < 2^13 is (x * HOUR_RECIP) >> 21
   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   // floor(x / 15) for x < 2^10 is (x * MIN_RECIP) >> 14
   localparam logic [10:0] MIN_RECIP  = 11'd1093;
   // about 2^22 / 365.25, estimate is within one of the true year
   localparam logic [13:0] YEAR_RECIP = 14'd11483;

   // Days before each month in a common year, last entry is the full year
   localparam logic [8:0] CUM_DAYS [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };

   // Gregorian leap rule for 2000 + y, y below 200
   function automatic logic leap_of(input logic [7:0] y);
      return (y[1:0] == 2'd0) && (y != 8'd100);
   endfunction

   // Days from 2000-01-01 to the first day of year 2000 + y
   function automatic logic [16:0] year_base(input logic [7:0] y);
      logic [8:0] quads;
      quads = (9'(y) + 9'd3) >> 2;
      return 17'(y) * 17'd365 + 17'(quads) - ((y > 8'd100) ? 17'd1 : 17'd0);
   endfunction

   // Days before month k + 1 of a year, k counts whole months (0 to 12)
   function automatic logic [8:0] month_start(input logic [3:0] k, input logic leap);
      logic [3:0] kk;
      kk = (k > 4'd12) ? 4'd12 : k;
      return CUM_DAYS[kk] + ((leap && kk >= 4'd2) ? 9'd1 : 9'd0);
   endfunction

endpackage

`default_nettype wire

// File: hdl/rtcat_fwd.sv
// Forward conversion: date and time to seconds since 2000, plus offset.
// Depends on rtcat_pkg. Three register stages.
`default_nettype none

module rtcat_fwd import rtcat_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire req_type     in_data,
   output logic             out_valid,
   output logic [31:0]      out_target
);

   logic        v1_ff, v2_ff, v3_ff;
   logic [31:0] days1_ff, days1_in;
   logic [16:0] sod1_ff, sod1_in, sod2_ff;
   logic [31:0] off1_ff, off2_ff;
   logic [31:0] prod2_ff, prod2_in;
   logic [31:0] target3_ff, target3_in;
   logic        cur_leap;
   logic [3:0]  mk;

   // Stage 1: day count and second of day
   always_comb begin
      cur_leap = leap_of(8'(in_data.cur_year));
      if (in_data.cur_month == 4'd0)
         mk = 4'd0;
      else
         mk = in_data.cur_month - 4'd1;
      days1_in = 32'(year_base(8'(in_data.cur_year)))
               + 32'(month_start(mk, cur_leap))
               + 32'(in_data.cur_day) - 32'd1;
      sod1_in = 17'(in_data.cur_hours) * 17'd3600
              + 17'(in_data.cur_minutes) * 17'd60
              + 17'(in_data.cur_seconds);
   end

   // Stage 2: days to seconds, stage 3: add time of day and offset
   assign prod2_in   = days1_ff * DAY_SECS;
   assign target3_in = prod2_ff + 32'(sod2_ff) + off2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         days1_ff   <= days1_in;
         sod1_ff    <= sod1_in;
         off1_ff    <= in_data.offset_seconds;
         prod2_ff   <= prod2_in;
         sod2_ff    <= sod1_ff;
         off2_ff    <= off1_ff;
         target3_ff <= target3_in;
      end
   end

   assign out_valid  = v3_ff;
   assign out_target = target3_ff;

endmodule

`default_nettype wire

// File: hdl/rtcat_div.sv
// Splits target seconds into whole days and second of day.
// Depends on rtcat_pkg. Two register stages, reciprocal multiply.
`default_nettype none

module rtcat_div import rtcat_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_target,
   output logic             out_valid,
   output div_type          out_data
);

   logic        v4_ff, v5_ff;
   logic [50:0] qprod;
   logic [15:0] q4_ff, q4_in;
   logic [31:0] target4_ff;
   logic [31:0] qsecs;
   div_type     d5_ff, d5_in;

   // Stage 4: quotient by 86400 = 128 * 675
   always_comb begin
      qprod = 51'(in_target[31:7]) * 51'(DAY_RECIP);
      q4_in = qprod[50:35];
   end

   // Stage 5: remainder from quotient
   always_comb begin
      qsecs        = 32'(q4_ff) * DAY_SECS;
      d5_in.target = target4_ff;
      d5_in.left   = q4_ff;
      d5_in.rem    = target4_ff[16:0] - qsecs[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q4_ff      <= q4_in;
         target4_ff <= in_target;
         d5_ff      <= d5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = d5_ff;

endmodule

`default_nettype wire

// File: hdl/rtcat_cal.sv
// Calendar stages: year, month, day and hour, minute, second of target.
// Depends on rtcat_pkg. Four register stages, last one is the output.
`default_nettype none

module rtcat_cal import rtcat_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   en,
   input  wire logic   in_valid,
   input  wire div_type in_data,
   output logic        out_valid,
   output rsp_type     out_data
);

   logic        v6_ff, v7_ff, v8_ff, v9_ff;
   // stage 6
   logic [26:0] hprod;
   logic [29:0] yprod;
   logic [4:0]  hrs6_ff, hrs6_in;
   logic [7:0]  ye6_ff, ye6_in;
   div_type     d6_ff;
   // stage 7
   logic [16:0] hsecs;
   logic [11:0] s7_ff, s7_in;
   logic [16:0] b0_ff, b1_ff, b2_ff;
   logic [7:0]  ye7_ff;
   logic [15:0] left7_ff;
   logic [31:0] target7_ff;
   logic [4:0]  hrs7_ff;
   // stage 8
   logic [19:0] mprod;
   logic [5:0]  mins8_ff, mins8_in;
   logic [7:0]  y8_ff, y8_in;
   logic [16:0] dsub;
   logic [8:0]  doy8_ff, doy8_in;
   logic        leap8_ff;
   logic [11:0] s8_ff;
   logic [31:0] target8_ff;
   logic [4:0]  hrs8_ff;
   // stage 9
   logic [11:0] msecs;
   logic [3:0]  mon;
   logic [8:0]  mday;
   rsp_type     r9_ff, r9_in;

   // Stage 6: hour by 3600 = 16 * 225, year estimate
   always_comb begin
      hprod   = 27'(in_data.rem[16:4]) * 27'(HOUR_RECIP);
      hrs6_in = hprod[25:21];
      yprod   = 30'(in_data.left) * 30'(YEAR_RECIP);
      ye6_in  = yprod[29:22];
   end

   // Stage 7: second of hour, start of candidate years
   always_comb begin
      hsecs = 17'(hrs6_ff) * 17'd3600;
      s7_in = 12'(d6_ff.rem - hsecs);
   end

   // Stage 8: minute by 60 = 4 * 15, pick the year
   always_comb begin
      mprod    = 20'(s7_ff[11:2]) * 20'(MIN_RECIP);
      mins8_in = mprod[19:14];
      if (17'(left7_ff) >= b2_ff) begin
         y8_in = ye7_ff + 8'd1;
         dsub  = 17'(left7_ff) - b2_ff;
      end else if (17'(left7_ff) >= b1_ff) begin
         y8_in = ye7_ff;
         dsub  = 17'(left7_ff) - b1_ff;
      end else begin
         y8_in = ye7_ff - 8'd1;
         dsub  = 17'(left7_ff) - b0_ff;
      end
      doy8_in = dsub[8:0];
   end

   // Stage 9: month search over the eleven month boundaries
   always_comb begin
      msecs = 12'(mins8_ff) * 12'd60;
      mon   = 4'd1;
      for (int k = 1; k < 12; k++) begin
         if (doy8_ff >= month_start(4'(k), leap8_ff))
            mon = 4'(k + 1);
      end
      mday = doy8_ff - month_start(mon - 4'd1, leap8_ff) + 9'd1;
      r9_in.target_epoch  = target8_ff;
      r9_in.alarm_year    = y8_ff;
      r9_in.alarm_month   = mon;
      r9_in.alarm_day     = mday[4:0];
      r9_in.alarm_hours   = hrs8_ff;
      r9_in.alarm_minutes = mins8_ff;
      r9_in.alarm_seconds = 6'(s8_ff - msecs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= in_valid;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hrs6_ff    <= hrs6_in;
         ye6_ff     <= ye6_in;
         d6_ff      <= in_data;
         s7_ff      <= s7_in;
         b0_ff      <= year_base(ye6_ff - 8'd1);
         b1_ff      <= year_base(ye6_ff);
         b2_ff      <= year_base(ye6_ff + 8'd1);
         ye7_ff     <= ye6_ff;
         left7_ff   <= d6_ff.left;
         target7_ff <= d6_ff.target;
         hrs7_ff    <= hrs6_ff;
         mins8_ff   <= mins8_in;
         y8_ff      <= y8_in;
         doy8_ff    <= doy8_in;
         leap8_ff   <= leap_of(y8_in);
         s8_ff      <= s7_ff;
         target8_ff <= target7_ff;
         hrs8_ff    <= hrs7_ff;
         r9_ff      <= r9_in;
      end
   end

   assign out_valid = v9_ff;
   assign out_data  = r9_ff;

endmodule

`default_nettype wire

// File: hdl/rtc_alarm_time_calculator_unit.sv
// Alarm time calculator: rtcat_fwd, then rtcat_div, then rtcat_cal, all registered.
// Throughput one item per cycle; the whole pipeline holds while the result
// is stalled, so req_stall follows rsp_stall with a valid result waiting.
// Synchronous reset clears all stage valid bits; payload is not reset.
// Depends on rtcat_pkg, rtcat_fwd, rtcat_div, rtcat_cal.
`default_nettype none

module rtc_alarm_time_calculator_unit import rtcat_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic        en;
   logic        fwd_valid, div_valid;
   logic [31:0] fwd_target;
   div_type     div_data;

   // Global advance: hold everything while the output is stalled
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   rtcat_fwd u_fwd (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .in_data    (req_data),
      .out_valid  (fwd_valid),
      .out_target (fwd_target)
   );

   rtcat_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fwd_valid),
      .in_target (fwd_target),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   rtcat_cal u_cal (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hdl/rtcat_checker.sv
// Port-level checks for the alarm time calculator, bound to the top level.
// Depends on rtcat_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rtcat_checker import rtcat_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // nothing comes out in the cycle after reset
   `ASSERT_RST(a_reset_idle, clock, reset, $past(reset) |-> !rsp_valid, "result right after reset")

   // input is held back only by a stalled result
   `ASSERT_ALWAYS(a_stall_cause, clock, req_stall |-> (rsp_valid && rsp_stall), "needless stall")

   // split fields stay in calendar range
   `ASSERT_RST(a_range, clock, reset,
      rsp_valid |-> (rsp_data.alarm_month >= 4'd1 && rsp_data.alarm_month <= 4'd12 &&
      rsp_data.alarm_day >= 5'd1 && rsp_data.alarm_hours <= 5'd23 &&
      rsp_data.alarm_minutes <= 6'd59 && rsp_data.alarm_seconds <= 6'd59 &&
      rsp_data.alarm_year <= 8'd136), "field out of range")

   // a stalled result stays valid
   `ASSERT_RST(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result dropped")

   logic unused_in;
   assign unused_in = req_valid ^ (^req_data);

endmodule

bind rtc_alarm_time_calculator_unit rtcat_checker u_rtcat_checker (.*);

`default_nettype wire

// File: test/rtc_alarm_time_calculator_unit_chk.sv
// Checker for the alarm time calculator: watches both channels, predicts
// each result from the request transfer and compares the whole result.
// Depends on rtcat_pkg.
`default_nettype none

module rtc_alarm_time_calculator_unit_chk import rtcat_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);

   rsp_type alarm_q[$];

   // Gregorian leap test for 2000 + y
   function automatic bit is_leap(input int unsigned y);
      int unsigned full;
      full = 2000 + y;
      return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
      int unsigned len [12];
      len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m < 1 || m > 12) return 0;
      if (m == 2 && is_leap(y)) return 29;
      return len[m - 1];
   endfunction

   // Date to seconds since 2000, add offset, then back to a calendar date
   function automatic rsp_type calc_alarm(input req_type r);
      rsp_type res;
      bit [31:0] days, now, target, left, rem, y, m;
      days = 0;
      for (int unsigned i = 0; i < r.cur_year; i++) days += 365 + is_leap(i);
      for (int unsigned i = 1; i < r.cur_month; i++) days += days_in_month(r.cur_year, i);
      days += 32'(r.cur_day) - 32'd1;
      now = days * 32'd86400 + 32'(r.cur_hours) * 32'd3600 + 32'(r.cur_minutes) * 32'd60
            + 32'(r.cur_seconds);
      target = now + r.offset_seconds;
      left = target / 32'd86400;
      rem = target % 32'd86400;
      y = 0;
      while (left >= 365 + is_leap(y)) begin
         left -= 365 + is_leap(y);
         y++;
      end
      m = 1;
      while (m <= 12 && left >= days_in_month(y, m)) begin
         left -= days_in_month(y, m);
         m++;
      end
      res.target_epoch  = target;
      res.alarm_year    = y[7:0];
      res.alarm_month   = m[3:0];
      res.alarm_day     = 5'(left + 1);
      res.alarm_hours   = 5'(rem / 3600);
      res.alarm_minutes = 6'((rem % 3600) / 60);
      res.alarm_seconds = 6'(rem % 60);
      return res;
   endfunction

   assign pending_count = alarm_q.size();

   // Predict on request transfers, compare on result transfers
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) alarm_q.push_back(calc_alarm(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (alarm_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transfer: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = alarm_q.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10) $display("result mismatch: expected %p actual %p",
                                                want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: test/rtc_alarm_time_calculator_unit_tb.sv
// Testbench top for the alarm time calculator: clock, reset, stimulus and
// verdict. Depends on rtcat_pkg, the block and rtc_alarm_time_calculator_unit_chk.
`default_nettype none

module rtc_alarm_time_calculator_unit_tb;
   import rtcat_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   bit      calm = 1'b0;   // stretch with no idling on either side

   rtc_alarm_time_calculator_unit i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   rtc_alarm_time_calculator_unit_chk i_chk (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .fail_count, .pending_count
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 15);
   end

   // Drive one item and hold it until the transfer
   task automatic send_item(input req_type item);
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type rand_item();
      req_type r;
      // any bit pattern in every field
      r.cur_year       = 7'($urandom());
      r.cur_month      = 4'($urandom());
      r.cur_day        = 5'($urandom());
      r.cur_hours      = 5'($urandom());
      r.cur_minutes    = 6'($urandom());
      r.cur_seconds    = 6'($urandom());
      r.offset_seconds = $urandom();
      if ($urandom_range(9) != 0) begin
         // mostly well-formed dates, half of them with a moderate offset
         r.cur_year    = 7'($urandom_range(99));
         r.cur_month   = 4'($urandom_range(12, 1));
         r.cur_day     = 5'($urandom_range(31, 1));
         r.cur_hours   = 5'($urandom_range(23));
         r.cur_minutes = 6'($urandom_range(59));
         r.cur_seconds = 6'($urandom_range(59));
         case ($urandom_range(3))
            0: r.offset_seconds = $urandom_range(86400);
            1: r.offset_seconds = $urandom_range(40000000);
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic req_type make_item(input int y, mo, d, h, mi, s, input bit [31:0] off);
      req_type r;
      r.cur_year = 7'(y); r.cur_month = 4'(mo); r.cur_day = 5'(d);
      r.cur_hours = 5'(h); r.cur_minutes = 6'(mi); r.cur_seconds = 6'(s);
      r.offset_seconds = off;
      return r;
   endfunction

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: field extremes, leap days, month zero, past December, day zero
      send_item(make_item(0, 1, 1, 0, 0, 0, 0));
      send_item(make_item(99, 12, 31, 23, 59, 59, 0));
      send_item(make_item(0, 1, 1, 0, 0, 0, 32'hFFFF_FFFF));
      send_item(make_item(99, 12, 31, 23, 59, 59, 32'hFFFF_FFFF));
      send_item(make_item(0, 2, 29, 0, 0, 0, 0));
      send_item(make_item(4, 2, 28, 23, 59, 59, 1));
      send_item(make_item(100, 2, 28, 23, 59, 59, 1));
      send_item(make_item(0, 0, 5, 1, 2, 3, 0));
      send_item(make_item(5, 13, 1, 0, 0, 0, 0));
      send_item(make_item(5, 15, 31, 31, 63, 63, 0));
      send_item(make_item(0, 1, 0, 0, 0, 0, 0));
      send_item(make_item(10, 3, 0, 0, 0, 0, 100));
      send_item(make_item(127, 15, 31, 31, 63, 63, 32'hFFFF_FFFF));
      send_item(make_item(127, 0, 0, 0, 0, 0, 0));
      send_item(make_item(0, 12, 31, 23, 59, 59, 1));
      send_item(make_item(1, 1, 1, 0, 0, 0, 32'h8000_0000));
      // Random items, with a calm stretch in the middle
      for (int n = 0; n < 1300; n++) begin
         calm = (n >= 500 && n < 650);
         send_item(rand_item());
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_count != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
